// ----- hw/rtl/percolation_cluster_grower_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the percolation cluster grower.
// ---------------------------------------------------------------------------
`ifndef PERCOLATION_CLUSTER_GROWER_MACROS_SVH
`define PERCOLATION_CLUSTER_GROWER_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define PCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when the trigger holds, the consequence holds in the next cycle.
`define PCG_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pcg_pkg.sv -----
// ---------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants of the percolation cluster grower.
// ---------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

  localparam int unsigned GridSideMax = 128;
  localparam int unsigned CoordW      = 7;
  localparam int unsigned SideW       = 8;
  localparam int unsigned CellAddrW   = 2 * CoordW;
  localparam int unsigned GridDepth   = GridSideMax * GridSideMax;
  localparam int unsigned FrontDepth  = 65536;
  localparam int unsigned FrontAddrW  = 16;
  localparam int unsigned CntW        = 17;
  localparam int unsigned BurntW      = 15;
  localparam int unsigned RandBits    = 16;
  localparam int unsigned ProdW       = CntW + RandBits;
  localparam int unsigned CellW       = 2;
  localparam int unsigned RegIdxW     = 2;

  localparam logic [CellW-1:0] CellUnburnt = 2'd0;
  localparam logic [CellW-1:0] CellBurnt   = 2'd1;
  localparam logic [CellW-1:0] CellUndef   = 2'd2;

  localparam logic [RegIdxW-1:0] RegThreshold = 2'd0;
  localparam logic [RegIdxW-1:0] RegSide      = 2'd1;
  localparam logic [RegIdxW-1:0] RegLimit     = 2'd2;

  localparam logic FuncStart = 1'b0;

  typedef enum logic [11:0] {
    StIdle   = 12'b0000_0000_0001,
    StClr    = 12'b0000_0000_0010,
    StCentre = 12'b0000_0000_0100,
    StMul    = 12'b0000_0000_1000,
    StRd1    = 12'b0000_0001_0000,
    StRd2    = 12'b0000_0010_0000,
    StMove   = 12'b0000_0100_0000,
    StGrid   = 12'b0000_1000_0000,
    StMod    = 12'b0001_0000_0000,
    StNbRd   = 12'b0010_0000_0000,
    StNbChk  = 12'b0100_0000_0000,
    StDone   = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [CellAddrW-1:0] addr;
    logic [CellW-1:0]     wdata;
  } grid_req_t;

  typedef struct packed {
    logic                  we;
    logic [FrontAddrW-1:0] addr;
    logic [CellAddrW-1:0]  wdata;
  } front_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcg_grid_ram.sv -----
// ---------------------------------------------------------------------------
// pcg_grid_ram
// Cell state memory, one read or write a cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pcg_grid_ram
  import pcg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire grid_req_t        req_i,
  output logic [CellW-1:0]      rdata_o
);

  logic [CellW-1:0] mem [GridDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcg_front_ram.sv -----
// ---------------------------------------------------------------------------
// pcg_front_ram
// Frontier list memory, one read or write a cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pcg_front_ram
  import pcg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire front_req_t       req_i,
  output logic [CellAddrW-1:0]  rdata_o
);

  logic [CellAddrW-1:0] mem [FrontDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/percolation_cluster_grower.sv -----
// A start word clears the grid, one cell a cycle, then burns the centre cell and checks its
// four neighbors. A step word picks a frontier site; if the site burns, subtraction rounds
// run while stored coordinates reach or exceed a reduced side, then four neighbor checks
// follow. A step word that decides no site goes straight to the result. One word in work at
// a time; the next is taken after the result is registered, while it waits to be read.
// Reset restores the registers, control and counters.
// ---------------------------------------------------------------------------
// percolation_cluster_grower
// Leath growth of a site-percolation cluster on a periodic square grid.
// ---------------------------------------------------------------------------
`default_nettype none
`include "percolation_cluster_grower_macros.svh"

module percolation_cluster_grower
  import pcg_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,  // pick_rand[15:0], fire_rand[31:16]
  input  wire logic         s_axis_tuser,  // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // site_x[6:0], site_y[13:7], site_burnt[14], frontier_count[31:15],
  // burnt_total[46:32], finished[47]
  output logic [47:0]       m_axis_tdata,
  output logic              m_axis_tuser,  // site_valid
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [RegIdxW-1:0] cfg_index_i,
  input  wire logic [CntW-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [CntW-1:0]   thr_q, limit_q;
  logic [SideW-1:0]  side_q;
  logic [CntW-1:0]   size_q, size_d, step_q, step_d;
  logic [BurntW-1:0] burnt_q, burnt_d;
  logic [RandBits-1:0] pick_q, fire_q;
  logic [ProdW-1:0]  prod_q;
  logic [CellAddrW-1:0] cell_q, cell_d, nb_q, nb_d, clr_q, clr_d;
  logic [CoordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [1:0]        k_q, k_d;
  logic              rv_q, rv_d, rb_q, rb_d;
  logic [CoordW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic              ov_q;
  logic [47:0]       od_q;
  logic              ou_q;

  grid_req_t  greq;
  front_req_t freq;
  logic [CellW-1:0]     grd;
  logic [CellAddrW-1:0] frd;

  logic [SideW-1:0]  s_used;
  logic [CoordW-1:0] cen, xm, xp, ym, yp, nx, ny;
  logic              out_free, fin;
  logic [FrontAddrW-1:0] pick_idx;

  pcg_grid_ram u_grid (.clk_i(clk_i), .req_i(greq), .rdata_o(grd));
  pcg_front_ram u_front (.clk_i(clk_i), .req_i(freq), .rdata_o(frd));

  assign s_used = (side_q < SideW'(2)) ? SideW'(2) :
                  (side_q > SideW'(GridSideMax)) ? SideW'(GridSideMax) : side_q;
  assign cen = s_used[CoordW:1];
  assign xm  = (cx_q == '0) ? CoordW'(s_used - 8'd1) : cx_q - 7'd1;
  assign xp  = ({1'b0, cx_q} + 8'd1 == s_used) ? '0 : cx_q + 7'd1;
  assign ym  = (cy_q == '0) ? CoordW'(s_used - 8'd1) : cy_q - 7'd1;
  assign yp  = ({1'b0, cy_q} + 8'd1 == s_used) ? '0 : cy_q + 7'd1;
  assign pick_idx = prod_q[ProdW-2:RandBits];

  always_comb begin
    nx = cx_q;
    ny = cy_q;
    case (k_q)
      2'd0:    nx = xm;
      2'd1:    nx = xp;
      2'd2:    ny = ym;
      default: ny = yp;
    endcase
  end

  assign out_free = !ov_q || m_axis_tready;
  assign fin = (size_q == '0) || (step_q >= limit_q);
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    step_d  = step_q;
    burnt_d = burnt_q;
    cell_d  = cell_q;
    nb_d    = nb_q;
    clr_d   = clr_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    k_d     = k_q;
    rv_d    = rv_q;
    rb_d    = rb_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    greq    = '{we: 1'b0, addr: cell_q, wdata: CellUndef};
    freq    = '{we: 1'b0, addr: pick_idx, wdata: frd};
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          rv_d = 1'b0;
          rb_d = 1'b0;
          rx_d = '0;
          ry_d = '0;
          if (s_axis_tuser == FuncStart) begin
            clr_d   = '0;
            state_d = StClr;
          end else if (step_q < limit_q) begin
            step_d  = step_q + 17'd1;
            state_d = (size_q != '0) ? StMul : StDone;
          end else begin
            state_d = StDone;
          end
        end
      end
      StClr: begin
        greq  = '{we: 1'b1, addr: clr_q, wdata: CellUndef};
        clr_d = clr_q + 14'd1;
        if (&clr_q) begin
          state_d = StCentre;
        end
      end
      StCentre: begin
        greq    = '{we: 1'b1, addr: {cen, cen}, wdata: CellBurnt};
        size_d  = '0;
        step_d  = '0;
        burnt_d = BurntW'(1);
        cx_d    = cen;
        cy_d    = cen;
        rv_d    = 1'b1;
        rb_d    = 1'b1;
        rx_d    = cen;
        ry_d    = cen;
        state_d = StMod;
      end
      StMul: begin
        state_d = StRd1;
      end
      StRd1: begin
        state_d = StRd2;
      end
      StRd2: begin
        cell_d  = frd;
        freq    = '{we: 1'b0, addr: FrontAddrW'(size_q - 17'd1), wdata: frd};
        size_d  = size_q - 17'd1;
        state_d = StMove;
      end
      StMove: begin
        freq    = '{we: 1'b1, addr: pick_idx, wdata: frd};
        rv_d    = 1'b1;
        rx_d    = cell_q[CellAddrW-1:CoordW];
        ry_d    = cell_q[CoordW-1:0];
        state_d = StGrid;
      end
      StGrid: begin
        if ({1'b0, fire_q} < thr_q) begin
          greq = '{we: 1'b1, addr: cell_q, wdata: CellBurnt};
          if (grd != CellBurnt) begin
            burnt_d = burnt_q + 15'd1;
          end
          rb_d    = 1'b1;
          cx_d    = cell_q[CellAddrW-1:CoordW];
          cy_d    = cell_q[CoordW-1:0];
          state_d = StMod;
        end else begin
          greq = '{we: 1'b1, addr: cell_q, wdata: CellUnburnt};
          if (grd == CellBurnt) begin
            burnt_d = burnt_q - 15'd1;
          end
          state_d = StDone;
        end
      end
      StMod: begin
        if ({1'b0, cx_q} >= s_used) begin
          cx_d = CoordW'({1'b0, cx_q} - s_used);
        end
        if ({1'b0, cy_q} >= s_used) begin
          cy_d = CoordW'({1'b0, cy_q} - s_used);
        end
        if (({1'b0, cx_q} < s_used) && ({1'b0, cy_q} < s_used)) begin
          k_d     = '0;
          state_d = StNbRd;
        end
      end
      StNbRd: begin
        nb_d    = {nx, ny};
        greq    = '{we: 1'b0, addr: {nx, ny}, wdata: CellUndef};
        state_d = StNbChk;
      end
      StNbChk: begin
        if ((grd == CellUndef) && (size_q < CntW'(FrontDepth))) begin
          freq   = '{we: 1'b1, addr: size_q[FrontAddrW-1:0], wdata: nb_q};
          size_d = size_q + 17'd1;
        end
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd3) ? StDone : StNbRd;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      thr_q   <= CntW'(32768);
      side_q  <= SideW'(100);
      limit_q <= CntW'(100000);
      size_q  <= '0;
      step_q  <= '0;
      burnt_q <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      step_q  <= step_d;
      burnt_q <= burnt_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegThreshold: thr_q   <= cfg_data_i;
          RegSide:      side_q  <= cfg_data_i[SideW-1:0];
          RegLimit:     limit_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (state_q == StDone && out_free) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    nb_q   <= nb_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    rv_q   <= rv_d;
    rb_q   <= rb_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    if (s_axis_tvalid && s_axis_tready) begin
      pick_q <= s_axis_tdata[15:0];
      fire_q <= s_axis_tdata[31:16];
    end
    if (state_q == StMul) begin
      prod_q <= ProdW'(size_q) * ProdW'(pick_q);
    end
    if (state_q == StDone && out_free) begin
      ou_q <= rv_q;
      od_q <= {fin, burnt_q, size_q, rb_q, ry_q, rx_q};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

  `PCG_ASSERT(a_size_bound, size_q <= CntW'(FrontDepth), "frontier size beyond depth")
  `PCG_ASSERT(a_pick_in_range, (state_q != StRd1) || (CntW'(pick_idx) < size_q), "bad pick")
  `PCG_ASSERT_NEXT(a_clr_walk, (state_q == StClr) && !(&clr_q), clr_q == $past(clr_q) + 14'd1, "skip")
  `PCG_ASSERT(a_out_fin, !m_axis_tvalid || (m_axis_tdata[31:15] != '0) || m_axis_tdata[47], "fin")

endmodule

`default_nettype wire
